/* rtl/core/lz_gamma_depacker_top_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the depacker top level.
// ---------------------------------------------------------------------------
`ifndef LZ_GAMMA_DEPACKER_TOP_ASSERT_SVH
`define LZ_GAMMA_DEPACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LZGD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzgd: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define LZGD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzgd: next-cycle check failed");

`endif

/* rtl/core/lzgd_pkg.sv */
// ---------------------------------------------------------------------------
// lzgd_pkg
// Shared types and constants of the LZ gamma depacker.
// ---------------------------------------------------------------------------
`default_nettype none

package lzgd_pkg;

  // Window and stream constants.
  localparam int unsigned WINDOW_SIZE  = 65536;
  localparam int unsigned HIST_AW      = $clog2(WINDOW_SIZE);
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned LIMIT_W      = 27;
  localparam int unsigned GAMMA_W      = 27;
  localparam int unsigned COUNT_W      = 28;

  localparam logic [31:0]        END_CODE    = 32'd767;
  localparam logic [31:0]        FAR_DIST    = 32'd3328;
  localparam logic [GAMMA_W-1:0] GAMMA_CAP   = 27'h200_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 27'h400_0000;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_PULSE = 2'd1,
    KIND_END   = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_HEADER  = 3'd1,
    ERR_TRUNC   = 3'd2,
    ERR_LITERAL = 3'd3,
    ERR_OFFSET  = 3'd4,
    ERR_LENGTH  = 3'd5,
    ERR_REF     = 3'd6
  } err_t;

  // Decode phases of the token parser.
  typedef enum logic [3:0] {
    PH_TOKEN  = 4'd0,
    PH_LIT    = 4'd1,
    PH_OG_A   = 4'd2,
    PH_OG_B   = 4'd3,
    PH_OBYTE  = 4'd4,
    PH_SEL_HI = 4'd5,
    PH_SEL_LO = 4'd6,
    PH_LG_A   = 4'd7,
    PH_LG_B   = 4'd8,
    PH_COPY   = 4'd9
  } phase_t;

  // Item sequencer states.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_RUN    = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_FIN    = 4'b1000
  } fsm_t;

endpackage

`default_nettype wire

/* rtl/core/lzgd_in_if.sv */
// ---------------------------------------------------------------------------
// lzgd_in_if
// Input channel: compressed byte, continue pulse or end of section.
// ---------------------------------------------------------------------------
`default_nettype none

interface lzgd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/lzgd_out_if.sv */
// ---------------------------------------------------------------------------
// lzgd_out_if
// Result channel: one result beat for every input beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface lzgd_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       need_byte;
  logic       done_res;
  logic [2:0] error;

  modport source (output valid, output out_valid, output out_byte, output need_byte,
                  output done_res, output error, input ready);
  modport sink   (input valid, input out_valid, input out_byte, input need_byte,
                  input done_res, input error, output ready);
endinterface

`default_nettype wire

/* rtl/core/lzgd_ram.sv */
// ---------------------------------------------------------------------------
// lzgd_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lzgd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/lz_gamma_depacker_top.sv */
// ---------------------------------------------------------------------------
// lz_gamma_depacker_top
// Streaming LZ depacker with Elias-gamma tokens and a history RAM.
// ---------------------------------------------------------------------------
// Usage:
//  in_ch carries items: a compressed byte, a continue pulse or end of section.
//  out_ch returns exactly one result beat per input beat, in order.
//  cfg_we/cfg_wdata write the output limit; write only while the block idles.
// Timing:
//  An item is taken in the idle state, then the parser runs one decode step per
//  cycle (one tag bit, a byte or a copy set-up), so a byte item or a pulse
//  runs up to fifteen tag bits, then a copied byte or a stalled step, and then
//  loads its result. A copied byte is read through the registered read port
//  of the history RAM and then written back. Header bytes, end items and
//  items after the section has finished go straight to the result load.
// Reset:
//  rst clears the parser and sets the output limit to 2^26. The history RAM
//  is not cleared; only bytes of the current section are ever read.
// Stalls:
//  The result sits in an output register. While it is not taken, the
//  next item may still be accepted and decoded; it waits before its own
//  result is loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module lz_gamma_depacker_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [lzgd_pkg::LIMIT_W-1:0] cfg_wdata,
  lzgd_in_if.sink                           in_ch,
  lzgd_out_if.source                        out_ch
);

  // Sequencer and parser state.
  lzgd_pkg::fsm_t   state, state_next;
  lzgd_pkg::phase_t phase, phase_next;
  logic [7:0]                         tag, tag_next;
  logic [3:0]                         header_left, header_left_next;
  logic [31:0]                        last_dist, last_dist_next;
  logic [lzgd_pkg::LIMIT_W-1:0]       bytes_written, bytes_written_next;
  logic [lzgd_pkg::GAMMA_W-1:0]       gacc, gacc_next;
  logic [31:0]                        mdist, mdist_next;
  logic [lzgd_pkg::COUNT_W-1:0]       copy_left, copy_left_next;
  logic [lzgd_pkg::HIST_AW-1:0]       copy_ptr, copy_ptr_next;
  logic                               sel_hi, sel_hi_next;
  logic                               fin_done, fin_done_next;
  logic                               fin_fail, fin_fail_next;
  logic [2:0]                         err, err_next;
  logic [lzgd_pkg::LIMIT_W-1:0]       limit;
  logic                               have_byte, have_byte_next;
  logic [7:0]                         offered, offered_next;
  logic                               item_ov, item_ov_next;
  logic [7:0]                         item_ob, item_ob_next;
  logic                               end_item, end_item_next;
  logic                               end_done, end_done_next;
  logic [2:0]                         end_err, end_err_next;
  logic                               rearm;

  // Output register.
  logic       out_full;
  logic       res_ov;
  logic [7:0] res_ob;
  logic       res_need;
  logic       res_done;
  logic [2:0] res_err;
  logic       out_load;

  // History RAM port signals.
  logic                         ram_we;
  logic [lzgd_pkg::HIST_AW-1:0] ram_waddr;
  logic [7:0]                   ram_wdata;
  logic [7:0]                   ram_rdata;

  lzgd_ram #(
    .WIDTH (8),
    .DEPTH (lzgd_pkg::WINDOW_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (copy_ptr),
    .rdata (ram_rdata)
  );

  // Tag bit fetch: refill from the offered byte when the tag runs dry.
  logic       fb_load;
  logic       fb_ok;
  logic       fb_bit;
  logic [7:0] fb_tag;

  assign fb_load = (tag[6:0] == 7'd0);
  assign fb_ok   = !fb_load || have_byte;
  assign fb_bit  = fb_load ? offered[7] : tag[7];
  assign fb_tag  = fb_load ? {offered[6:0], 1'b1} : {tag[6:0], 1'b0};

  // Match set-up: length, count and reference check.
  logic [1:0]                   sel_code;
  logic [lzgd_pkg::COUNT_W-1:0] cp_len;
  logic [lzgd_pkg::COUNT_W-1:0] cp_count;
  logic [lzgd_pkg::COUNT_W-1:0] cp_end;
  logic                         cp_bad;
  logic [31:0]                  enc;

  assign sel_code = {sel_hi, fb_bit};
  assign cp_len   = (phase == lzgd_pkg::PH_SEL_LO) ?
                    {{(lzgd_pkg::COUNT_W-2){1'b0}}, sel_code} :
                    ({1'b0, gacc} + lzgd_pkg::COUNT_W'(2));
  assign cp_count = cp_len + lzgd_pkg::COUNT_W'(1)
                    + lzgd_pkg::COUNT_W'(mdist > lzgd_pkg::FAR_DIST);
  assign cp_end   = {1'b0, bytes_written} + cp_count;
  assign cp_bad   = (mdist == 32'd0)
                    || (mdist > {{(32-lzgd_pkg::LIMIT_W){1'b0}}, bytes_written})
                    || (mdist > 32'(lzgd_pkg::WINDOW_SIZE))
                    || (cp_end > {1'b0, limit});
  assign enc      = {gacc[23:0], offered};

  // Section verdict code for an early end.
  logic [2:0] trunc_code;

  always_comb begin
    trunc_code = lzgd_pkg::ERR_TRUNC;
    if (header_left != 4'd0) begin
      trunc_code = lzgd_pkg::ERR_HEADER;
    end else begin
      case (phase)
        lzgd_pkg::PH_LIT:    trunc_code = lzgd_pkg::ERR_LITERAL;
        lzgd_pkg::PH_OG_A,
        lzgd_pkg::PH_OG_B,
        lzgd_pkg::PH_OBYTE:  trunc_code = lzgd_pkg::ERR_OFFSET;
        lzgd_pkg::PH_SEL_HI,
        lzgd_pkg::PH_SEL_LO,
        lzgd_pkg::PH_LG_A,
        lzgd_pkg::PH_LG_B:   trunc_code = lzgd_pkg::ERR_LENGTH;
        default:             trunc_code = lzgd_pkg::ERR_TRUNC;
      endcase
    end
  end

  // Result fields, taken from the state once an item has run.
  logic need_now;

  assign need_now = !(fin_done || fin_fail)
                    && ((header_left != 4'd0)
                        || (phase == lzgd_pkg::PH_LIT)
                        || (phase == lzgd_pkg::PH_OBYTE)
                        || ((phase != lzgd_pkg::PH_COPY) && fb_load));

  assign in_ch.ready = (state == lzgd_pkg::S_IDLE);
  assign out_load    = (state == lzgd_pkg::S_FIN) && (!out_full || out_ch.ready);

  // Decode step: one parser step per cycle, plus item entry and copy write-back.
  always_comb begin
    state_next         = state;
    phase_next         = phase;
    tag_next           = tag;
    header_left_next   = header_left;
    last_dist_next     = last_dist;
    bytes_written_next = bytes_written;
    gacc_next          = gacc;
    mdist_next         = mdist;
    copy_left_next     = copy_left;
    copy_ptr_next      = copy_ptr;
    sel_hi_next        = sel_hi;
    fin_done_next      = fin_done;
    fin_fail_next      = fin_fail;
    err_next           = err;
    have_byte_next     = have_byte;
    offered_next       = offered;
    item_ov_next       = item_ov;
    item_ob_next       = item_ob;
    end_item_next      = end_item;
    end_done_next      = end_done;
    end_err_next       = end_err;
    rearm              = 1'b0;
    ram_we             = 1'b0;
    ram_waddr          = bytes_written[lzgd_pkg::HIST_AW-1:0];
    ram_wdata          = offered;

    case (state)
      lzgd_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          item_ov_next  = 1'b0;
          item_ob_next  = 8'd0;
          offered_next  = in_ch.in_byte;
          state_next    = lzgd_pkg::S_FIN;
          if (in_ch.kind == lzgd_pkg::KIND_END) begin
            end_item_next = 1'b1;
            end_done_next = fin_done;
            end_err_next  = (fin_done || fin_fail) ? err : trunc_code;
            rearm         = 1'b1;
          end else begin
            end_item_next  = 1'b0;
            have_byte_next = (in_ch.kind == lzgd_pkg::KIND_BYTE);
            if (!(fin_done || fin_fail)) begin
              if (header_left != 4'd0) begin
                if (in_ch.kind == lzgd_pkg::KIND_BYTE) begin
                  header_left_next = header_left - 4'd1;
                end
              end else begin
                state_next = lzgd_pkg::S_RUN;
              end
            end
          end
        end
      end

      lzgd_pkg::S_RUN: begin
        case (phase)
          lzgd_pkg::PH_LIT: begin
            state_next     = lzgd_pkg::S_FIN;
            have_byte_next = 1'b0;
            if (have_byte) begin
              if (bytes_written >= limit) begin
                fin_fail_next = 1'b1;
                err_next      = lzgd_pkg::ERR_LITERAL;
              end else begin
                ram_we             = 1'b1;
                bytes_written_next = bytes_written + lzgd_pkg::LIMIT_W'(1);
                item_ov_next       = 1'b1;
                item_ob_next       = offered;
                phase_next         = lzgd_pkg::PH_TOKEN;
              end
            end
          end

          lzgd_pkg::PH_OG_A, lzgd_pkg::PH_LG_A: begin
            if (!fb_ok) begin
              state_next = lzgd_pkg::S_FIN;
            end else begin
              tag_next       = fb_tag;
              have_byte_next = have_byte && !fb_load;
              gacc_next      = {gacc[lzgd_pkg::GAMMA_W-2:0], fb_bit};
              phase_next     = (phase == lzgd_pkg::PH_OG_A) ?
                               lzgd_pkg::PH_OG_B : lzgd_pkg::PH_LG_B;
            end
          end

          lzgd_pkg::PH_OG_B: begin
            if (!fb_ok) begin
              state_next = lzgd_pkg::S_FIN;
            end else begin
              tag_next       = fb_tag;
              have_byte_next = have_byte && !fb_load;
              if (fb_bit) begin
                if (gacc == lzgd_pkg::GAMMA_W'(2)) begin
                  mdist_next = last_dist;
                  phase_next = lzgd_pkg::PH_SEL_HI;
                end else begin
                  phase_next = lzgd_pkg::PH_OBYTE;
                end
              end else if (gacc > lzgd_pkg::GAMMA_CAP) begin
                fin_fail_next = 1'b1;
                err_next      = lzgd_pkg::ERR_OFFSET;
                state_next    = lzgd_pkg::S_FIN;
              end else begin
                phase_next = lzgd_pkg::PH_OG_A;
              end
            end
          end

          lzgd_pkg::PH_OBYTE: begin
            if (!have_byte) begin
              state_next = lzgd_pkg::S_FIN;
            end else begin
              have_byte_next = 1'b0;
              if (enc == lzgd_pkg::END_CODE) begin
                fin_done_next = 1'b1;
                state_next    = lzgd_pkg::S_FIN;
              end else begin
                mdist_next     = enc - lzgd_pkg::END_CODE;
                last_dist_next = enc - lzgd_pkg::END_CODE;
                phase_next     = lzgd_pkg::PH_SEL_HI;
              end
            end
          end

          lzgd_pkg::PH_SEL_HI: begin
            if (!fb_ok) begin
              state_next = lzgd_pkg::S_FIN;
            end else begin
              tag_next       = fb_tag;
              have_byte_next = have_byte && !fb_load;
              sel_hi_next    = fb_bit;
              phase_next     = lzgd_pkg::PH_SEL_LO;
            end
          end

          lzgd_pkg::PH_SEL_LO, lzgd_pkg::PH_LG_B: begin
            if (!fb_ok) begin
              state_next = lzgd_pkg::S_FIN;
            end else begin
              tag_next       = fb_tag;
              have_byte_next = have_byte && !fb_load;
              if ((phase == lzgd_pkg::PH_SEL_LO && sel_code != 2'd0)
                  || (phase == lzgd_pkg::PH_LG_B && fb_bit)) begin
                // Start a match copy, or flag a bad reference.
                if (cp_bad) begin
                  fin_fail_next = 1'b1;
                  err_next      = lzgd_pkg::ERR_REF;
                  state_next    = lzgd_pkg::S_FIN;
                end else begin
                  copy_left_next = cp_count;
                  copy_ptr_next  = bytes_written[lzgd_pkg::HIST_AW-1:0]
                                   - mdist[lzgd_pkg::HIST_AW-1:0];
                  phase_next     = lzgd_pkg::PH_COPY;
                end
              end else if (phase == lzgd_pkg::PH_SEL_LO) begin
                gacc_next  = lzgd_pkg::GAMMA_W'(1);
                phase_next = lzgd_pkg::PH_LG_A;
              end else if (gacc > lzgd_pkg::GAMMA_CAP) begin
                fin_fail_next = 1'b1;
                err_next      = lzgd_pkg::ERR_LENGTH;
                state_next    = lzgd_pkg::S_FIN;
              end else begin
                phase_next = lzgd_pkg::PH_LG_A;
              end
            end
          end

          lzgd_pkg::PH_COPY: begin
            // The read of the source byte is under way; wait for its data.
            state_next = lzgd_pkg::S_RDWAIT;
          end

          default: begin
            phase_next = lzgd_pkg::PH_TOKEN;
            if (!fb_ok) begin
              state_next = lzgd_pkg::S_FIN;
            end else begin
              tag_next       = fb_tag;
              have_byte_next = have_byte && !fb_load;
              if (fb_bit) begin
                phase_next = lzgd_pkg::PH_LIT;
              end else begin
                gacc_next  = lzgd_pkg::GAMMA_W'(1);
                phase_next = lzgd_pkg::PH_OG_A;
              end
            end
          end
        endcase
      end

      lzgd_pkg::S_RDWAIT: begin
        // Copy write-back of the byte just read.
        ram_we             = 1'b1;
        ram_wdata          = ram_rdata;
        bytes_written_next = bytes_written + lzgd_pkg::LIMIT_W'(1);
        item_ov_next       = 1'b1;
        item_ob_next       = ram_rdata;
        copy_ptr_next      = copy_ptr + lzgd_pkg::HIST_AW'(1);
        if (copy_left != '0) begin
          copy_left_next = copy_left - lzgd_pkg::COUNT_W'(1);
        end
        if (copy_left <= lzgd_pkg::COUNT_W'(1)) begin
          phase_next = lzgd_pkg::PH_TOKEN;
        end
        state_next = lzgd_pkg::S_FIN;
      end

      lzgd_pkg::S_FIN: begin
        if (out_load) begin
          have_byte_next = 1'b0;
          state_next     = lzgd_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = lzgd_pkg::S_IDLE;
      end
    endcase
  end

  // Result fields for the output register.
  assign res_ov   = item_ov;
  assign res_ob   = item_ob;
  assign res_need = end_item ? 1'b1 : need_now;
  assign res_done = end_item ? end_done : fin_done;
  assign res_err  = end_item ? end_err : err;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst || rearm) begin
      phase         <= lzgd_pkg::PH_TOKEN;
      tag           <= 8'd0;
      header_left   <= 4'(lzgd_pkg::HEADER_BYTES);
      last_dist     <= 32'd1;
      bytes_written <= '0;
      gacc          <= lzgd_pkg::GAMMA_W'(1);
      mdist         <= 32'd0;
      copy_left     <= '0;
      copy_ptr      <= '0;
      sel_hi        <= 1'b0;
      fin_done      <= 1'b0;
      fin_fail      <= 1'b0;
      err           <= lzgd_pkg::ERR_NONE;
      have_byte     <= 1'b0;
    end else begin
      phase         <= phase_next;
      tag           <= tag_next;
      header_left   <= header_left_next;
      last_dist     <= last_dist_next;
      bytes_written <= bytes_written_next;
      gacc          <= gacc_next;
      mdist         <= mdist_next;
      copy_left     <= copy_left_next;
      copy_ptr      <= copy_ptr_next;
      sel_hi        <= sel_hi_next;
      fin_done      <= fin_done_next;
      fin_fail      <= fin_fail_next;
      err           <= err_next;
      have_byte     <= have_byte_next;
    end
  end

  // Sequencer state and item bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lzgd_pkg::S_IDLE;
      end_item <= 1'b0;
    end else begin
      state    <= state_next;
      end_item <= end_item_next;
    end
  end

  // Per-item payload registers.
  always_ff @(posedge clk) begin
    offered  <= offered_next;
    item_ov  <= item_ov_next;
    item_ob  <= item_ob_next;
    end_done <= end_done_next;
    end_err  <= end_err_next;
  end

  // Output limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= lzgd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  // Output register: holds a result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
    end else if (out_ch.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.out_valid <= res_ov;
      out_ch.out_byte  <= res_ob;
      out_ch.need_byte <= res_need;
      out_ch.done_res  <= res_done;
      out_ch.error     <= res_err;
    end
  end

  assign out_ch.valid = out_full;

  // Checks on the sequencer and parser.
`include "lz_gamma_depacker_top_assert.svh"

  `LZGD_ASSERT_NOW(a_rdwait_in_copy, state == lzgd_pkg::S_RDWAIT, phase == lzgd_pkg::PH_COPY)
  `LZGD_ASSERT_NOW(a_done_xor_fail, 1'b1, !(fin_done && fin_fail))
  `LZGD_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, state != lzgd_pkg::S_IDLE)
  `LZGD_ASSERT_NEXT(a_fin_loads, out_load, out_full && state == lzgd_pkg::S_IDLE)

endmodule

`default_nettype wire

/* tb/sv/lzgd_tb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzgd_tb_pkg
// Constants of the stimulus side of the depacker test.
// ---------------------------------------------------------------------------
package lzgd_tb_pkg;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 40;
endpackage

/* tb/sv/lzgd_chk.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lzgd_chk
// Watches both channels of the depacker, runs a behavioural copy of the
// decoder on every accepted item and compares each result beat with it.
// ---------------------------------------------------------------------------
module lzgd_chk
  import lzgd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_wdata,
  lzgd_in_if                  in_ch,
  lzgd_out_if                 out_ch,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic       ovld;
    logic [7:0] obyte;
    logic       need;
    logic       done;
    err_t       err;
  } result_t;

  result_t     expected_q[$];
  logic [7:0]  history_ram [WINDOW_SIZE];
  logic [31:0] out_limit;
  logic [31:0] tag_reg;
  logic [31:0] hdr_left;
  logic [31:0] last_dist;
  logic [31:0] written;
  phase_t      phase;
  logic [31:0] gamma;
  logic [31:0] match_dist;
  logic [31:0] copy_cnt;
  logic [31:0] copy_ptr;
  logic [1:0]  fin;
  err_t        err_reg;
  logic        byte_held;
  logic [7:0]  byte_val;

  // Return the decoder to the start of a section.
  task automatic new_section();
    tag_reg = 0; hdr_left = HEADER_BYTES; last_dist = 1; written = 0;
    phase = PH_TOKEN; gamma = 1; match_dist = 0; copy_cnt = 0; copy_ptr = 0;
    fin = 2'b00; err_reg = ERR_NONE;
  endtask

  task automatic abort_with(err_t code);
    fin = 2'b10;
    err_reg = code;
  endtask

  // Pull one tag bit; returns 0 when a fresh tag byte is needed but absent.
  function automatic bit pull_bit(output logic b);
    logic [31:0] t;
    t = (tag_reg << 1) & 32'hFFFF;
    if ((t & 32'hFF) == 0) begin
      if (!byte_held) return 0;
      byte_held = 0;
      tag_reg = ({24'd0, byte_val} << 1 | 1) & 32'hFFFF;
      b = byte_val[7];
      return 1;
    end
    tag_reg = t;
    b = t[8];
    return 1;
  endfunction

  function automatic err_t cut_code();
    if (hdr_left > 0) return ERR_HEADER;
    case (phase)
      PH_LIT: return ERR_LITERAL;
      PH_OG_A, PH_OG_B, PH_OBYTE: return ERR_OFFSET;
      PH_SEL_HI, PH_SEL_LO, PH_LG_A, PH_LG_B: return ERR_LENGTH;
      default: return ERR_TRUNC;
    endcase
  endfunction

  task automatic begin_copy(logic [31:0] len);
    logic [63:0] cnt;
    if (match_dist > FAR_DIST) len++;
    cnt = 64'(len) + 1;
    if (match_dist == 0 || match_dist > written || match_dist > WINDOW_SIZE
        || 64'(written) + cnt > 64'(out_limit)) begin
      abort_with(ERR_REF);
      return;
    end
    copy_cnt = cnt[31:0];
    copy_ptr = (written - match_dist) % WINDOW_SIZE;
    phase = PH_COPY;
  endtask

  task automatic store_byte(logic [7:0] v);
    history_ram[written % WINDOW_SIZE] = v;
    written = (written + 1) & 32'h7FF_FFFF;
  endtask

  // Work out the result beat caused by one accepted item.
  task automatic decode_item(logic [1:0] kind, logic [7:0] data, output result_t r);
    logic stop, b;
    logic [31:0] enc;
    logic [2:0] sel;
    r = '0;
    stop = 0;
    b = 0;
    if (kind == KIND_END) begin
      if (fin == 0) abort_with(cut_code());
      r.need = 1; r.done = fin[0]; r.err = err_reg;
      new_section();
      return;
    end
    byte_held = (kind == KIND_BYTE);
    byte_val = data;
    if (fin != 0) stop = 1;
    else if (hdr_left > 0) begin
      if (byte_held) hdr_left--;
      stop = 1;
    end
    while (!stop && fin == 0) begin
      case (phase)
        PH_LIT: begin
          if (!byte_held) stop = 1;
          else begin
            byte_held = 0;
            if (written >= out_limit) abort_with(ERR_LITERAL);
            else begin
              store_byte(byte_val);
              r.ovld = 1; r.obyte = byte_val;
              phase = PH_TOKEN; stop = 1;
            end
          end
        end
        PH_OG_A, PH_LG_A: begin
          if (!pull_bit(b)) stop = 1;
          else begin
            gamma = (gamma << 1) + b;
            phase = (phase == PH_OG_A) ? PH_OG_B : PH_LG_B;
          end
        end
        PH_OG_B: begin
          if (!pull_bit(b)) stop = 1;
          else if (b) begin
            if (gamma == 2) begin
              match_dist = last_dist; phase = PH_SEL_HI;
            end else phase = PH_OBYTE;
          end else if (gamma > GAMMA_CAP) abort_with(ERR_OFFSET);
          else phase = PH_OG_A;
        end
        PH_OBYTE: begin
          if (!byte_held) stop = 1;
          else begin
            byte_held = 0;
            enc = (gamma << 8) + byte_val;
            if (enc == END_CODE) fin = 2'b01;
            else begin
              match_dist = enc - END_CODE;
              last_dist = match_dist;
              phase = PH_SEL_HI;
            end
          end
        end
        PH_SEL_HI: begin
          if (!pull_bit(b)) stop = 1;
          else begin
            copy_cnt = b; phase = PH_SEL_LO;
          end
        end
        PH_SEL_LO: begin
          if (!pull_bit(b)) stop = 1;
          else begin
            sel = {1'b0, copy_cnt[0], b};
            if (sel != 0) begin_copy(32'(sel));
            else begin
              gamma = 1; phase = PH_LG_A;
            end
          end
        end
        PH_LG_B: begin
          if (!pull_bit(b)) stop = 1;
          else if (b) begin_copy(gamma + 2);
          else if (gamma > GAMMA_CAP) abort_with(ERR_LENGTH);
          else phase = PH_LG_A;
        end
        PH_COPY: begin
          r.obyte = history_ram[copy_ptr % WINDOW_SIZE];
          store_byte(r.obyte);
          r.ovld = 1;
          copy_ptr = (copy_ptr + 1) % WINDOW_SIZE;
          if (copy_cnt > 0) copy_cnt--;
          if (copy_cnt == 0) phase = PH_TOKEN;
          stop = 1;
        end
        default: begin
          if (!pull_bit(b)) stop = 1;
          else if (b) phase = PH_LIT;
          else begin
            gamma = 1; phase = PH_OG_A;
          end
        end
      endcase
    end
    byte_held = 0;
    if (fin != 0) r.need = 0;
    else if (hdr_left > 0) r.need = 1;
    else if (phase == PH_LIT || phase == PH_OBYTE) r.need = 1;
    else if (phase == PH_COPY) r.need = 0;
    else r.need = (((tag_reg << 1) & 32'hFF) == 0);
    r.done = fin[0];
    r.err = err_reg;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Predict on input beats, compare on result beats.
  always @(posedge clk) begin
    result_t r, e;
    if (rst) begin
      out_limit = LIMIT_RESET;
      new_section();
      expected_q.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_we) out_limit = 32'(cfg_wdata);
      if (in_ch.valid && in_ch.ready) begin
        decode_item(in_ch.kind, in_ch.in_byte, r);
        expected_q = {expected_q, r};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) report_mismatch("unexpected beat", 1, 0);
        else begin
          e = expected_q.pop_front();
          if (out_ch.out_valid !== e.ovld)
            report_mismatch("out_valid", out_ch.out_valid, e.ovld);
          if (out_ch.out_byte !== e.obyte)
            report_mismatch("out_byte", out_ch.out_byte, e.obyte);
          if (out_ch.need_byte !== e.need)
            report_mismatch("need_byte", out_ch.need_byte, e.need);
          if (out_ch.done_res !== e.done)
            report_mismatch("done_res", out_ch.done_res, e.done);
          if (out_ch.error !== e.err)
            report_mismatch("error", out_ch.error, e.err);
        end
      end
      pending = expected_q.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives compressed sections into the depacker: a directed set of corner
// sections, then random well-formed streams mixed with noise, under several
// idling patterns and output limits. The checker delivers the verdict count.
// ---------------------------------------------------------------------------
module tb_top;
  import lzgd_pkg::*;
  import lzgd_tb_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  int fail_count, pending;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  logic watchdog_hit = 0;

  lzgd_in_if  in_ch();
  lzgd_out_if out_ch();

  lz_gamma_depacker_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  lzgd_chk u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .fail_count(fail_count), .pending(pending)
  );

  // Clock.
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver with random stalls.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) watchdog_hit <= 1;
    end
  end

  always @(posedge watchdog_hit) begin
    $display("watchdog expired at %0t", $time);
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one item and hold it until accepted.
  task automatic send_item(kind_t k, logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.kind <= k;
    in_ch.in_byte <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] d);
    send_item(KIND_BYTE, d);
  endtask

  // Settle the block, then write the limit register.
  task automatic write_limit(logic [LIMIT_W-1:0] v);
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Bit writer for building well-formed streams.
  int         tag_pos;
  logic [7:0] stream[$];
  int         tag_idx;

  task automatic put_bit(bit b);
    if (tag_pos == 0) begin
      stream = {stream, 8'h00};
      tag_idx = stream.size() - 1;
      tag_pos = 8;
    end
    tag_pos--;
    stream[tag_idx][tag_pos] = b;
  endtask

  task automatic put_gamma(int unsigned v);
    int msb;
    msb = $clog2(v + 1) - 1;
    for (int i = msb - 1; i >= 0; i--) begin
      put_bit(v[i]);
      put_bit(i == 0);
    end
  endtask

  // Build a stream: literals and matches, with an optional end token.
  // The end token needs a gamma of 2^24 + 2 so that the encoded value wraps to 767.
  task automatic build_section(int tokens, bit with_end, int spread);
    int produced, gap, len, enc;
    bit have_last;
    stream.delete();
    tag_pos = 0;
    produced = 0;
    have_last = 0;
    for (int i = 0; i < 8; i++) stream = {stream, 8'($urandom)};
    for (int t = 0; t < tokens; t++) begin
      if (produced == 0 || $urandom_range(2) == 0) begin
        put_bit(1);
        stream = {stream, 8'($urandom)};
        produced++;
      end else begin
        put_bit(0);
        if (have_last && $urandom_range(3) == 0) begin
          put_gamma(2);
          gap = 0;
        end else begin
          gap = $urandom_range(produced, 1);
          if ($urandom_range(spread) == 0) gap = $urandom_range(produced + 2, 0);
          enc = gap + 767;
          put_gamma(enc >> 8);
          stream = {stream, 8'(enc)};
          have_last = 1;
        end
        len = $urandom_range(3, 0);
        if (len == 0) begin
          put_bit(0); put_bit(0);
          put_gamma($urandom_range(6, 2));
        end else begin
          put_bit(len[1]); put_bit(len[0]);
        end
        produced += 8;
      end
    end
    if (with_end) begin
      put_bit(0);
      put_gamma(32'h0100_0002);
      stream = {stream, 8'hFF};
    end
  endtask

  // Send the built stream, sprinkling continue pulses and spare items and ending the section.
  task automatic play_section(int cut);
    int n;
    n = (cut >= 0 && cut < stream.size()) ? cut : stream.size();
    for (int i = 0; i < n; i++) begin
      send_byte(stream[i]);
      while ($urandom_range(3) != 0 && items_sent < 400000)
        send_item($urandom_range(1) ? KIND_PULSE : KIND_SPARE, 8'($urandom));
    end
    repeat ($urandom_range(3)) send_item(KIND_PULSE, 8'($urandom));
    send_item(KIND_END, 8'($urandom));
  endtask

  task automatic noise_items(int n);
    for (int i = 0; i < n; i++)
      send_item(kind_t'($urandom_range(3)), 8'($urandom));
  endtask

  initial begin
    int phase_no, target;
    in_ch.valid <= 0;
    in_ch.kind <= KIND_PULSE;
    in_ch.in_byte <= 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: short header, empty section, extreme bytes.
    send_item(KIND_END, 8'h00);
    send_byte(8'h00); send_byte(8'hFF); send_item(KIND_END, 8'hFF);
    build_section(0, 1, 1);
    play_section(-1);
    // Literal straight into a limit of one, then over it.
    write_limit(LIMIT_W'(1));
    build_section(3, 1, 100);
    play_section(-1);
    // Bad reference and repeat-offset paths with the maximum limit.
    write_limit(27'h7FF_FFFF);
    build_section(4, 1, 0);
    play_section(-1);
    // Long runs of zero tag bits overflow the offset gamma.
    for (int i = 0; i < 8; i++) send_byte(8'h55);
    send_byte(8'h00); send_byte(8'h00);
    for (int i = 0; i < 6; i++) send_byte(8'h00);
    send_item(KIND_END, 8'h00);
    write_limit(LIMIT_RESET);

    // Random phases over idling patterns and limits.
    target = 1350;
    phase_no = 0;
    while (items_sent < target) begin
      case (phase_no % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (phase_no % 3 == 2) write_limit(LIMIT_W'($urandom_range(60, 1)));
      else if (phase_no % 3 == 1) write_limit(27'h7FF_FFFF);
      for (int s = 0; s < 4 && items_sent < target; s++) begin
        build_section($urandom_range(12, 1), $urandom_range(3) != 0, 8);
        play_section($urandom_range(5) == 0 ? $urandom_range(stream.size()) : -1);
      end
      noise_items(10);
      phase_no++;
    end
    send_item(KIND_END, 8'h00);

    // Drain.
    in_ch.valid <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
